FILE: sv/voxel_grid_binning_accumulator_core_assert.svh
// Assertion macros shared by the voxel grid binning accumulator RTL.
`ifndef VOXEL_GRID_BINNING_ACCUMULATOR_CORE_ASSERT_SVH
`define VOXEL_GRID_BINNING_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define VGBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgba assertion failed");
// Next-cycle implication, checked out of reset.
`define VGBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgba assertion failed");
`else
`define VGBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VGBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/vgba_pkg.sv
// Shared constants and types of the voxel grid binning accumulator.
package vgba_pkg;

    localparam int GRID_POINTS_DEF = 64;

    localparam int DATA_W = 32;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 24;
    localparam int ADDR_W = 18;
    localparam int OP_W   = 2;

    localparam logic [DATA_W-1:0] INV_STEP_RST = 32'h0001_0000;

    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // One voxel entry as stored in memory
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } voxel_t;

endpackage

FILE: sv/vgba_div.sv
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
module vgba_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [vgba_pkg::SUM_W-1:0] dividend,
    input  logic [vgba_pkg::CNT_W-1:0]     divisor,
    output logic                           done,
    output logic signed [vgba_pkg::SUM_W-1:0] quotient
);
    import vgba_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;

    // Restoring step on the magnitude
    always_comb
    begin
        shifted   = {rem_reg, q_reg[SUM_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            neg_next = dividend[SUM_W-1];
            q_next   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            if (!diff[CNT_W])
            begin
                rem_next = diff[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        if (done_reg)
            quo_next = neg_reg ? (SUM_W'(0) - q_reg) : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // Sign fix-up lands in the cycle after the last step
    logic fin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= 1'b0;
        else
            fin_reg <= done_reg;
    end

    assign done     = fin_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/voxel_grid_binning_accumulator_core.sv
// Top level of the voxel grid binning accumulator core.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  item in  | start, busy        | op, vec_x, vec_y, vec_z, pixel_value,
//           |                    | voxel_address
//  result   | done (strobe)      | accepted, hit_address, mean_value,
//           |                    | sample_count
//  config   | cfg_we             | cfg_wdata (inv_step)
//
// Accumulate: one shared multiplier over three coordinates, then address
// build, memory read and write-back. Clear and read of an empty voxel skip
// the multiplier and address build. Read of a filled voxel adds the bit-serial
// divider. After reset a clearing pass zeroes the voxel memory, one entry per
// cycle (GRID_POINTS**3 entries, 262144 at default); busy is high meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
module voxel_grid_binning_accumulator_core #(
    parameter int GRID_POINTS = vgba_pkg::GRID_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [vgba_pkg::OP_W-1:0]          op,
    input  logic signed [vgba_pkg::DATA_W-1:0] vec_x,
    input  logic signed [vgba_pkg::DATA_W-1:0] vec_y,
    input  logic signed [vgba_pkg::DATA_W-1:0] vec_z,
    input  logic signed [vgba_pkg::DATA_W-1:0] pixel_value,
    input  logic [vgba_pkg::ADDR_W-1:0]        voxel_address,
    input  logic                               cfg_we,
    input  logic [vgba_pkg::DATA_W-1:0]        cfg_wdata,
    output logic                               done,
    output logic                               accepted,
    output logic [vgba_pkg::ADDR_W-1:0]        hit_address,
    output logic signed [vgba_pkg::SUM_W-1:0]  mean_value,
    output logic [vgba_pkg::CNT_W-1:0]         sample_count
);
    import vgba_pkg::*;

`include "voxel_grid_binning_accumulator_core_assert.svh"

    localparam int VOXELS = GRID_POINTS * GRID_POINTS * GRID_POINTS;
    localparam int AW     = $clog2(VOXELS);
    localparam int IW     = $clog2(GRID_POINTS);
    localparam int HALF   = GRID_POINTS / 2;
    localparam logic signed [32:0] Q_LO = -33'(HALF);
    localparam logic signed [32:0] Q_HI = 33'(GRID_POINTS - 1 - HALF);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_MOD  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [DATA_W-1:0]        inv_step_reg;
    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [1:0]               crd_cnt_reg, crd_cnt_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic signed [DATA_W-1:0] vec_reg [3];
    logic signed [DATA_W-1:0] vec_next [3];
    logic signed [DATA_W-1:0] pix_reg, pix_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic [IW-1:0]            idx_reg [3];
    logic [IW-1:0]            idx_next [3];
    logic [2:0]               ok_reg, ok_next;
    logic [AW-1:0]            mem_addr_reg, mem_addr_next;

    logic                     done_reg, done_next;
    logic                     acc_reg, acc_next;
    logic [ADDR_W-1:0]        hit_reg, hit_next;
    logic signed [SUM_W-1:0]  mean_reg, mean_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    voxel_t                   mem [VOXELS];
    voxel_t                   rd_data_reg;
    logic                     rd_en;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    voxel_t                   wr_data;

    logic signed [DATA_W-1:0] vec_sel;
    logic signed [63:0]       prod_full;
    logic [64:0]              rnd;
    logic signed [32:0]       q;
    logic [32:0]              qs;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     div_start;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_quo;

    // Coordinate multiplier, one coordinate per cycle
    always_comb
    begin
        case (crd_cnt_reg)
            2'd0:    vec_sel = vec_reg[0];
            2'd1:    vec_sel = vec_reg[1];
            default: vec_sel = vec_reg[2];
        endcase
        prod_full = vec_sel * $signed({1'b0, inv_step_reg});
    end

    // Round half up to floor, shift by half the grid
    always_comb
    begin
        rnd = {prod_reg[63], prod_reg} + 65'h0_8000_0000;
        q   = rnd[64:32];
        qs  = q - Q_LO;
    end

    // Saturating update of the voxel entry
    always_comb
    begin
        sum_wide = {rd_data_reg.sum[SUM_W-1], rd_data_reg.sum}
                 + (SUM_W+1)'(pix_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
        cnt_inc = (rd_data_reg.count == '1) ? rd_data_reg.count
                                            : rd_data_reg.count + CNT_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        crd_cnt_next  = crd_cnt_reg;
        op_next       = op_reg;
        vec_next      = vec_reg;
        pix_next      = pix_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        mem_addr_next = mem_addr_reg;
        done_next     = 1'b0;
        acc_next      = 1'b0;
        hit_next      = '0;
        mean_next     = '0;
        cnt_next      = '0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = mem_addr_reg;
        wr_data       = '0;
        div_start     = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(VOXELS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    vec_next[0] = vec_x;
                    vec_next[1] = vec_y;
                    vec_next[2] = vec_z;
                    pix_next    = pixel_value;
                    crd_cnt_next = '0;
                    if (op == OP_ACC)
                        state_next = ST_MUL;
                    else if ((op == OP_READ || op == OP_CLEAR) &&
                             (32'(voxel_address) < 32'(VOXELS)))
                    begin
                        mem_addr_next = AW'(voxel_address);
                        state_next    = ST_RD;
                    end
                    else
                        done_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next    = prod_full;
                crd_cnt_next = crd_cnt_reg + 2'd1;
                if (crd_cnt_reg != 2'd0)
                begin
                    idx_next[crd_cnt_reg - 2'd1] = qs[IW-1:0];
                    ok_next[crd_cnt_reg - 2'd1]  = (q >= Q_LO) && (q <= Q_HI);
                end
                if (crd_cnt_reg == 2'd3)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (ok_reg == 3'b111)
                begin
                    mem_addr_next = AW'(idx_reg[0]) * AW'(GRID_POINTS * GRID_POINTS)
                                  + AW'(idx_reg[1]) * AW'(GRID_POINTS)
                                  + AW'(idx_reg[2]);
                    state_next = ST_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                hit_next = ADDR_W'(mem_addr_reg);
                acc_next = 1'b1;
                if (op_reg == OP_ACC)
                begin
                    wr_en         = 1'b1;
                    wr_data.sum   = sum_sat;
                    wr_data.count = cnt_inc;
                    cnt_next      = cnt_inc;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (rd_data_reg.count == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    acc_next   = 1'b0;
                    hit_next   = '0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    acc_next   = 1'b1;
                    hit_next   = ADDR_W'(mem_addr_reg);
                    mean_next  = div_quo;
                    cnt_next   = rd_data_reg.count;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clr_cnt_reg  <= '0;
            inv_step_reg <= INV_STEP_RST;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (cfg_we)
                inv_step_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        crd_cnt_reg  <= crd_cnt_next;
        op_reg       <= op_next;
        vec_reg      <= vec_next;
        pix_reg      <= pix_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        ok_reg       <= ok_next;
        mem_addr_reg <= mem_addr_next;
        acc_reg      <= acc_next;
        hit_reg      <= hit_next;
        mean_reg     <= mean_next;
        cnt_reg      <= cnt_next;
    end

    // Voxel memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[mem_addr_reg];
    end

    vgba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg.sum),
        .divisor  (rd_data_reg.count),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign accepted     = acc_reg;
    assign hit_address  = hit_reg;
    assign mean_value   = mean_reg;
    assign sample_count = cnt_reg;

    // Checks
    `VGBA_ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, state_reg == ST_IDLE)
    `VGBA_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy && op == OP_ACC, busy)
    `VGBA_ASSERT_IMPLIES(a_miss_zero, clk, rst_n, done && !accepted, hit_address == '0 && mean_value == '0 && sample_count == '0)
    `VGBA_ASSERT_IMPLIES(a_init_busy, clk, rst_n, state_reg == ST_INIT, busy)
    `VGBA_ASSERT_IMPLIES(a_clear_zero, clk, rst_n, done && op_reg == OP_CLEAR, sample_count == '0 && mean_value == '0)

endmodule
